// File: hw/rtl/hlsd_pkg.sv
`timescale 1ns / 1ps
// hlsd_pkg: shared constants and types for the header-locked sample deframer
// no dependencies

package hlsd_pkg;

    localparam int LOOKAHEAD_FRAMES = 4;
    localparam int FRAME_BYTES      = 4;
    localparam int WIN_BYTES        = FRAME_BYTES * LOOKAHEAD_FRAMES;
    localparam int FILL_W           = $clog2(WIN_BYTES + 1);
    localparam int MAX_BLOCK        = 4096;
    localparam int FRAME_CNT_W      = $clog2(MAX_BLOCK);
    localparam int FPB_W            = FRAME_CNT_W + 1;
    localparam int CFG_INDEX_W      = 1;
    localparam int CFG_DATA_W       = FPB_W;

    localparam logic [7:0]       HEADER_RESET = 8'h55;
    localparam logic [FPB_W-1:0] FPB_RESET    = FPB_W'(512);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADER_VALUE     = 1'b0,
        CFG_FRAMES_PER_BLOCK = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        POS_HEADER  = 2'd0,
        POS_CUR_HI  = 2'd1,
        POS_CUR_LO  = 2'd2,
        POS_TEMP    = 2'd3
    } frame_pos_t;

    typedef struct packed {
        logic [15:0]            sensor_current;
        logic [7:0]             temperature;
        logic [FRAME_CNT_W-1:0] frame_index;
        logic                   block_last;
        logic [15:0]            block_max;
    } result_t;

endpackage

// File: hw/rtl/header_locked_sample_deframer_top.sv
`timescale 1ns / 1ps
// header_locked_sample_deframer_top: frame-sync deframer with lookahead window
// output: each frame's result is registered, into the skid entry if the output stalls
// throughput: one byte request per cycle unless both result entries hold results;
// a two-entry result buffer keeps intake running while one result waits on the output
// reset: asynchronous active-low, clears control state and restores register defaults
// depends on hlsd_pkg

module header_locked_sample_deframer_top
    import hlsd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [15:0]            sensor_current,
    output logic [7:0]             temperature,
    output logic [FRAME_CNT_W-1:0] frame_index,
    output logic                   block_last,
    output logic [15:0]            block_max
);

    logic [7:0]             header_reg;
    logic [FPB_W-1:0]       fpb_reg;
    logic [7:0]             window_reg [WIN_BYTES];
    logic [FILL_W-1:0]      fill_reg;
    logic                   locked_reg;
    frame_pos_t             pos_reg;
    logic [FRAME_CNT_W-1:0] cnt_reg;
    logic [7:0]             cur_hi_reg;
    logic [7:0]             cur_lo_reg;
    logic [15:0]            max_reg;
    logic                   out_valid_reg;
    result_t                out_reg;
    logic                   skid_valid_reg;
    result_t                skid_reg;

    logic                   accept;
    logic                   full;
    logic                   match;
    logic                   lock_now;
    logic                   active;
    frame_pos_t             pos;
    logic [FRAME_CNT_W-1:0] cnt;
    logic [15:0]            max_cur;
    logic [15:0]            cur;
    logic [15:0]            max_new;
    logic [FRAME_CNT_W-1:0] lim_m1;
    logic                   last;
    logic                   emit;
    result_t                res;
    logic [7:0]             leaving;

    logic                   locked_next;
    frame_pos_t             pos_next;
    logic [FRAME_CNT_W-1:0] cnt_next;
    logic [15:0]            max_next;

    assign accept   = in_valid && in_ready;
    assign in_ready = !skid_valid_reg;
    assign full     = (fill_reg == FILL_W'(WIN_BYTES));
    assign leaving  = window_reg[0];

    always_comb
    begin
        match = 1'b1;
        for (int f = 0; f < LOOKAHEAD_FRAMES; f++)
        begin
            if (window_reg[f * FRAME_BYTES] != header_reg)
            begin
                match = 1'b0;
            end
        end
    end

    always_comb
    begin
        if (fpb_reg == '0)
        begin
            lim_m1 = '0;
        end
        else if (fpb_reg > FPB_W'(MAX_BLOCK))
        begin
            lim_m1 = FRAME_CNT_W'(MAX_BLOCK - 1);
        end
        else
        begin
            lim_m1 = FRAME_CNT_W'(fpb_reg - FPB_W'(1));
        end
    end

    assign lock_now = !locked_reg && match;
    assign active   = locked_reg || match;
    assign pos      = lock_now ? POS_HEADER : pos_reg;
    assign cnt      = lock_now ? '0 : cnt_reg;
    assign max_cur  = lock_now ? '0 : max_reg;
    assign cur      = {cur_hi_reg, cur_lo_reg};
    assign max_new  = (cur > max_cur) ? cur : max_cur;
    assign last     = (cnt >= lim_m1);
    assign emit     = accept && full && active && (pos == POS_TEMP);

    always_comb
    begin
        res.sensor_current = cur;
        res.temperature    = leaving;
        res.frame_index    = cnt;
        res.block_last     = last;
        res.block_max      = max_new;
    end

    // frame tracking for the byte leaving the window
    always_comb
    begin
        locked_next = locked_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        max_next    = max_reg;
        if (accept && full && active)
        begin
            locked_next = 1'b1;
            cnt_next    = cnt;
            max_next    = max_cur;
            pos_next    = frame_pos_t'(pos + 2'd1);
            if (pos == POS_TEMP)
            begin
                if (last)
                begin
                    locked_next = 1'b0;
                    cnt_next    = '0;
                    max_next    = '0;
                    pos_next    = POS_HEADER;
                end
                else
                begin
                    cnt_next = cnt + FRAME_CNT_W'(1);
                    max_next = max_new;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= HEADER_RESET;
            fpb_reg    <= FPB_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_HEADER_VALUE:     header_reg <= cfg_data[7:0];
                CFG_FRAMES_PER_BLOCK: fpb_reg    <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            locked_reg <= 1'b0;
            pos_reg    <= POS_HEADER;
            cnt_reg    <= '0;
            max_reg    <= '0;
        end
        else
        begin
            if (accept && !full)
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            locked_reg <= locked_next;
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            max_reg    <= max_next;
        end
    end

    // window shift line and captured current bytes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WIN_BYTES - 1; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[WIN_BYTES - 1] <= rx_byte;
            if (full && active && (pos == POS_CUR_HI))
            begin
                cur_hi_reg <= leaving;
            end
            if (full && active && (pos == POS_CUR_LO))
            begin
                cur_lo_reg <= leaving;
            end
        end
    end

    // two-entry result buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= emit;
            end
        end
        else if (out_valid_reg)
        begin
            if (emit)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (emit)
            begin
                out_reg <= res;
            end
        end
        else if (out_valid_reg)
        begin
            if (emit)
            begin
                skid_reg <= res;
            end
        end
        else if (emit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign sensor_current = out_reg.sensor_current;
    assign temperature    = out_reg.temperature;
    assign frame_index    = out_reg.frame_index;
    assign block_last     = out_reg.block_last;
    assign block_max      = out_reg.block_max;

endmodule
